### design/pggbm_pkg.sv
// ----------------------------------------------------------------------------
// pggbm_pkg: shared definitions for the pixel grid greedy block merger
// Grid sizes, span limits, colour constants, action and register codes, and
// the one-hot sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package pggbm_pkg;

  // Grid geometry
  localparam int GRID_CELLS = 16384;
  localparam int MAX_SPAN   = 5;
  localparam int COORD_BITS = 12;

  localparam int ADDR_W = $clog2(GRID_CELLS);
  localparam int SP_W   = ADDR_W + 1;
  localparam int SPAN_W = $clog2(MAX_SPAN + 1);
  localparam int NB_W   = 2 * COORD_BITS + 2;

  // Shared divider sizes
  localparam int DIV_W  = 24;
  localparam int DEN_W  = COORD_BITS;
  localparam int DCNT_W = $clog2(DIV_W + 1);

  // Colour constants
  localparam int OPAQUE_MIN = 200;
  localparam int HUE_SEG    = 3840;
  localparam int CELL_W     = 25;
  localparam int HNUM_W     = 11;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_TOL   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MERGE_EN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_HEIGHT  = 3'd4;

  // Item actions
  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_LOAD  = 2'd1;
  localparam logic [1:0] ACT_FETCH = 2'd2;

  // Sequencer states
  typedef enum logic [19:0] {
    ST_CLEAR     = 20'h00001,
    ST_IDLE      = 20'h00002,
    ST_GEOM      = 20'h00004,
    ST_GEOM_MUL  = 20'h00008,
    ST_LOAD_MUL  = 20'h00010,
    ST_LOAD_WR   = 20'h00020,
    ST_F_START   = 20'h00040,
    ST_F_POS     = 20'h00080,
    ST_SCAN_RD   = 20'h00100,
    ST_SCAN_CHK  = 20'h00200,
    ST_RIGHT_RD  = 20'h00400,
    ST_RIGHT_CHK = 20'h00800,
    ST_DOWN_RD   = 20'h01000,
    ST_DOWN_CHK  = 20'h02000,
    ST_MARK      = 20'h04000,
    ST_HSV       = 20'h08000,
    ST_SAT       = 20'h10000,
    ST_HUE       = 20'h20000,
    ST_EMIT      = 20'h40000,
    ST_DIV       = 20'h80000
  } state_t;

endpackage

`default_nettype wire

### design/pixel_grid_greedy_block_merger.sv
// ----------------------------------------------------------------------------
// pixel_grid_greedy_block_merger: greedy rectangle merging over a pixel grid
// Samples loaded pixels into a cell memory, then on each fetch scans for the
// next unvisited opaque cell, grows a rectangle, marks it and reports HSV.
// ----------------------------------------------------------------------------
// Begin: accepted when idle, then a visited-map clear of GRID_CELLS entries
// (16384) and the geometry divisions; the same clear runs after reset. Load:
// a row offset product, then the store. Fetch: a division to locate the scan
// position, a read and a check per cell scanned and per merge probe, a write
// per marked cell, then the HSV divisions; all divisions share one restoring
// divider, and each memory has one write port and one registered read port.
// Reset is synchronous and active low; configuration is taken during the clear.
`default_nettype none

module pixel_grid_greedy_block_merger (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // Configuration write channel
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [pggbm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [pggbm_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Input item channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [1:0]                           in_action,
  input  wire logic [7:0]                           in_pixel_red,
  input  wire logic [7:0]                           in_pixel_green,
  input  wire logic [7:0]                           in_pixel_blue,
  input  wire logic [7:0]                           in_pixel_alpha,
  // Result item channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      out_scan_done,
  output logic [pggbm_pkg::COORD_BITS-1:0]          out_cell_column,
  output logic [pggbm_pkg::COORD_BITS-1:0]          out_cell_row,
  output logic [2:0]                                out_span_columns,
  output logic [2:0]                                out_span_rows,
  output logic [7:0]                                out_base_red,
  output logic [7:0]                                out_base_green,
  output logic [7:0]                                out_base_blue,
  output logic [14:0]                               out_hue_value,
  output logic [7:0]                                out_saturation_value,
  output logic [7:0]                                out_brightness_value
);

  import pggbm_pkg::*;

  // Sequencer and configuration registers
  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;
  logic [7:0]             step_r, step_nxt;
  logic [7:0]             tol_r, tol_nxt;
  logic                   merge_r, merge_nxt;
  logic [COORD_BITS-1:0]  width_r, width_nxt;
  logic [COORD_BITS-1:0]  height_r, height_nxt;

  // Geometry
  logic [COORD_BITS-1:0]  gw_r, gw_nxt;
  logic [COORD_BITS-1:0]  gh_r, gh_nxt;
  logic [SP_W-1:0]        end_r, end_nxt;
  logic [2:0]             geo_r, geo_nxt;

  // Load counters
  logic [COORD_BITS-1:0]  lcol_r, lcol_nxt;
  logic [COORD_BITS-1:0]  lrow_r, lrow_nxt;
  logic [COORD_BITS-1:0]  cq_r, cq_nxt;
  logic [7:0]             cr_r, cr_nxt;
  logic [COORD_BITS-1:0]  rq_r, rq_nxt;
  logic [7:0]             rr_r, rr_nxt;
  logic [CELL_W-1:0]      pix_r, pix_nxt;
  logic [2*COORD_BITS-1:0] prod_r, prod_nxt;

  // Scan and merge
  logic [SP_W-1:0]        sp_r, sp_nxt;
  logic [SP_W-1:0]        p_r, p_nxt;
  logic [COORD_BITS-1:0]  gx_r, gx_nxt;
  logic [COORD_BITS-1:0]  gy_r, gy_nxt;
  logic [23:0]            base_r, base_nxt;
  logic [SPAN_W-1:0]      spx_r, spx_nxt;
  logic [SPAN_W-1:0]      spy_r, spy_nxt;
  logic [SPAN_W-1:0]      dx_r, dx_nxt;
  logic [NB_W-1:0]        row_r, row_nxt;
  logic                   idx_ok_r, idx_ok_nxt;
  logic [NB_W-1:0]        mrow_r, mrow_nxt;
  logic [SPAN_W-1:0]      mdx_r, mdx_nxt;
  logic [SPAN_W-1:0]      mdy_r, mdy_nxt;
  logic [ADDR_W-1:0]      clr_r, clr_nxt;

  // Colour results
  logic [7:0]             mx_r, mx_nxt;
  logic [7:0]             d_r, d_nxt;
  logic [HNUM_W-1:0]      hnum_r, hnum_nxt;
  logic [7:0]             sat_r, sat_nxt;
  logic [14:0]            hue_r, hue_nxt;
  logic                   done_r, done_nxt;

  // Shared divider
  logic [DIV_W-1:0]       div_quo_r, div_quo_nxt;
  logic [DEN_W-1:0]       div_rem_r, div_rem_nxt;
  logic [DEN_W-1:0]       div_den_r, div_den_nxt;
  logic [DCNT_W-1:0]      div_cnt_r, div_cnt_nxt;
  logic                   div_go;
  logic [DIV_W-1:0]       div_num;
  logic [DEN_W-1:0]       div_den_in;
  state_t                 div_ret;
  logic [DEN_W:0]         div_t;
  logic                   div_ge;
  logic [DEN_W:0]         div_diff;

  // Output registers
  logic                   out_valid_r, out_valid_nxt;
  logic                   o_done_r, o_done_nxt;
  logic [COORD_BITS-1:0]  o_col_r, o_col_nxt;
  logic [COORD_BITS-1:0]  o_row_r, o_row_nxt;
  logic [2:0]             o_spx_r, o_spx_nxt;
  logic [2:0]             o_spy_r, o_spy_nxt;
  logic [23:0]            o_rgb_r, o_rgb_nxt;
  logic [14:0]            o_hue_r, o_hue_nxt;
  logic [7:0]             o_sat_r, o_sat_nxt;
  logic [7:0]             o_val_r, o_val_nxt;

  // Memories and their ports
  logic [CELL_W-1:0]      cell_mem [GRID_CELLS];
  logic                   vis_mem [GRID_CELLS];
  logic [CELL_W-1:0]      cell_rd_r;
  logic                   vis_rd_r;
  logic [ADDR_W-1:0]      rd_addr;
  logic                   cell_we;
  logic [ADDR_W-1:0]      cell_wa;
  logic                   vis_we;
  logic [ADDR_W-1:0]      vis_wa;
  logic                   vis_wd;

  // Helper values
  logic [7:0]             st;
  logic                   cfg_wr;
  logic                   in_acc;
  logic [NB_W-1:0]        load_idx;
  logic [COORD_BITS-1:0]  col_inc;
  logic [NB_W-1:0]        probe_idx;
  logic [NB_W-1:0]        mark_idx;
  logic                   join_ok;
  logic [7:0]             c_r, c_g, c_b, h_mn, h_d;
  logic [7:0]             h_mx;
  logic [HNUM_W-1:0]      h_num;
  logic [8:0]             ad_r, ad_g, ad_b;

  assign st        = (step_r == 8'd0) ? 8'd1 : step_r;
  assign cfg_ready = (state_r == ST_IDLE) || (state_r == ST_CLEAR);
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign in_acc    = in_valid && !in_stall;

  // Restoring divider step, one quotient bit a cycle
  assign div_t    = {div_rem_r, div_quo_r[DIV_W-1]};
  assign div_ge   = div_t >= {1'b0, div_den_r};
  assign div_diff = div_t - {1'b0, div_den_r};

  // Cell index of the loaded pixel and of the cell under test
  assign load_idx  = NB_W'(prod_r) + NB_W'(cq_r);
  assign mark_idx  = mrow_r + NB_W'(mdx_r);
  assign probe_idx = (state_r == ST_RIGHT_RD) ? (NB_W'(p_r) + NB_W'(spx_r))
                                              : (row_r + NB_W'(dx_r));

  // Merge test against the first cell of the block
  assign ad_r = (cell_rd_r[23:16] > base_r[23:16]) ?
                {1'b0, cell_rd_r[23:16]} - {1'b0, base_r[23:16]} :
                {1'b0, base_r[23:16]} - {1'b0, cell_rd_r[23:16]};
  assign ad_g = (cell_rd_r[15:8] > base_r[15:8]) ?
                {1'b0, cell_rd_r[15:8]} - {1'b0, base_r[15:8]} :
                {1'b0, base_r[15:8]} - {1'b0, cell_rd_r[15:8]};
  assign ad_b = (cell_rd_r[7:0] > base_r[7:0]) ?
                {1'b0, cell_rd_r[7:0]} - {1'b0, base_r[7:0]} :
                {1'b0, base_r[7:0]} - {1'b0, cell_rd_r[7:0]};
  assign join_ok = idx_ok_r && !vis_rd_r && cell_rd_r[CELL_W-1] &&
                   (ad_r <= {1'b0, tol_r}) && (ad_g <= {1'b0, tol_r}) &&
                   (ad_b <= {1'b0, tol_r});

  // Colour extremes and hue numerator of the first cell
  always_comb begin
    c_r  = base_r[23:16];
    c_g  = base_r[15:8];
    c_b  = base_r[7:0];
    h_mx = (c_r > c_g) ? c_r : c_g;
    if (c_b > h_mx) begin
      h_mx = c_b;
    end
    h_mn = (c_r < c_g) ? c_r : c_g;
    if (c_b < h_mn) begin
      h_mn = c_b;
    end
    h_d = h_mx - h_mn;
    if (h_mx == c_r) begin
      if (c_g >= c_b) begin
        h_num = HNUM_W'(c_g - c_b);
      end else begin
        h_num = HNUM_W'(6 * h_d) - HNUM_W'(c_b - c_g);
      end
    end else if (h_mx == c_g) begin
      h_num = HNUM_W'(c_b) + HNUM_W'(2 * h_d) - HNUM_W'(c_r);
    end else begin
      h_num = HNUM_W'(c_r) + HNUM_W'(4 * h_d) - HNUM_W'(c_g);
    end
  end

  // Main sequencer
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    step_nxt    = step_r;
    tol_nxt     = tol_r;
    merge_nxt   = merge_r;
    width_nxt   = width_r;
    height_nxt  = height_r;
    gw_nxt      = gw_r;
    gh_nxt      = gh_r;
    end_nxt     = end_r;
    geo_nxt     = geo_r;
    lcol_nxt    = lcol_r;
    lrow_nxt    = lrow_r;
    cq_nxt      = cq_r;
    cr_nxt      = cr_r;
    rq_nxt      = rq_r;
    rr_nxt      = rr_r;
    pix_nxt     = pix_r;
    prod_nxt    = prod_r;
    sp_nxt      = sp_r;
    p_nxt       = p_r;
    gx_nxt      = gx_r;
    gy_nxt      = gy_r;
    base_nxt    = base_r;
    spx_nxt     = spx_r;
    spy_nxt     = spy_r;
    dx_nxt      = dx_r;
    row_nxt     = row_r;
    idx_ok_nxt  = idx_ok_r;
    mrow_nxt    = mrow_r;
    mdx_nxt     = mdx_r;
    mdy_nxt     = mdy_r;
    clr_nxt     = clr_r;
    mx_nxt      = mx_r;
    d_nxt       = d_r;
    hnum_nxt    = hnum_r;
    sat_nxt     = sat_r;
    hue_nxt     = hue_r;
    done_nxt    = done_r;
    div_quo_nxt = div_quo_r;
    div_rem_nxt = div_rem_r;
    div_den_nxt = div_den_r;
    div_cnt_nxt = div_cnt_r;
    div_go      = 1'b0;
    div_num     = '0;
    div_den_in  = '0;
    div_ret     = ST_IDLE;
    rd_addr     = p_r[ADDR_W-1:0];
    cell_we     = 1'b0;
    cell_wa     = load_idx[ADDR_W-1:0];
    vis_we      = 1'b0;
    vis_wa      = clr_r;
    vis_wd      = 1'b0;
    col_inc     = lcol_r;
    out_valid_nxt = out_valid_r;
    o_done_nxt  = o_done_r;
    o_col_nxt   = o_col_r;
    o_row_nxt   = o_row_r;
    o_spx_nxt   = o_spx_r;
    o_spy_nxt   = o_spy_r;
    o_rgb_nxt   = o_rgb_r;
    o_hue_nxt   = o_hue_r;
    o_sat_nxt   = o_sat_r;
    o_val_nxt   = o_val_r;

    // A taken result frees the output register
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // Register writes
    if (cfg_wr) begin
      case (cfg_index)
        REG_SAMPLE_STEP: step_nxt   = cfg_data[7:0];
        REG_COLOR_TOL:   tol_nxt    = cfg_data[7:0];
        REG_MERGE_EN:    merge_nxt  = cfg_data[0];
        REG_IMG_WIDTH:   width_nxt  = cfg_data[COORD_BITS-1:0];
        REG_IMG_HEIGHT:  height_nxt = cfg_data[COORD_BITS-1:0];
        default: ;
      endcase
    end

    case (state_r)
      // Visited-map clear, one entry a cycle
      ST_CLEAR: begin
        vis_we  = 1'b1;
        vis_wa  = clr_r;
        vis_wd  = 1'b0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ADDR_W'(GRID_CELLS - 1)) begin
          geo_nxt   = '0;
          state_nxt = ST_GEOM;
        end
      end

      ST_IDLE: begin
        if (cfg_wr) begin
          geo_nxt   = '0;
          state_nxt = ST_GEOM;
        end else if (in_acc) begin
          case (in_action)
            ACT_BEGIN: begin
              lcol_nxt  = '0;
              lrow_nxt  = '0;
              cq_nxt    = '0;
              cr_nxt    = '0;
              rq_nxt    = '0;
              rr_nxt    = '0;
              sp_nxt    = '0;
              clr_nxt   = '0;
              state_nxt = ST_CLEAR;
            end
            ACT_LOAD: begin
              pix_nxt   = {(in_pixel_alpha >= 8'(OPAQUE_MIN)), in_pixel_red,
                           in_pixel_green, in_pixel_blue};
              state_nxt = ST_LOAD_MUL;
            end
            ACT_FETCH: begin
              state_nxt = ST_F_START;
            end
            default: ;
          endcase
        end
      end

      // Grid size and load position from the present registers
      ST_GEOM: begin
        div_go     = 1'b1;
        div_ret    = ST_GEOM;
        div_den_in = DEN_W'(st);
        geo_nxt    = geo_r + 1'b1;
        case (geo_r)
          3'd0: begin
            div_num = DIV_W'(width_r) + DIV_W'(st) - 1'b1;
          end
          3'd1: begin
            gw_nxt  = div_quo_r[COORD_BITS-1:0];
            div_num = DIV_W'(height_r) + DIV_W'(st) - 1'b1;
          end
          3'd2: begin
            gh_nxt  = div_quo_r[COORD_BITS-1:0];
            div_num = DIV_W'(lcol_r);
          end
          3'd3: begin
            cq_nxt  = div_quo_r[COORD_BITS-1:0];
            cr_nxt  = div_rem_r[7:0];
            div_num = DIV_W'(lrow_r);
          end
          default: begin
            div_go    = 1'b0;
            rq_nxt    = div_quo_r[COORD_BITS-1:0];
            rr_nxt    = div_rem_r[7:0];
            state_nxt = ST_GEOM_MUL;
          end
        endcase
      end

      ST_GEOM_MUL: begin
        prod_nxt = gw_r * gh_r;
        if ((gw_r * gh_r) >= (2*COORD_BITS)'(GRID_CELLS)) begin
          end_nxt = SP_W'(GRID_CELLS);
        end else begin
          end_nxt = SP_W'(gw_r * gh_r);
        end
        state_nxt = ST_IDLE;
      end

      // Load: row offset product, then store and advance
      ST_LOAD_MUL: begin
        prod_nxt  = rq_r * gw_r;
        state_nxt = ST_LOAD_WR;
      end

      ST_LOAD_WR: begin
        state_nxt = ST_IDLE;
        if (lrow_r < height_r) begin
          col_inc = lcol_r;
          if (lcol_r < width_r) begin
            if ((cr_r == 8'd0) && (rr_r == 8'd0) &&
                (load_idx < NB_W'(GRID_CELLS))) begin
              cell_we = 1'b1;
            end
            col_inc = lcol_r + 1'b1;
            if (({1'b0, cr_r} + 9'd1) == {1'b0, st}) begin
              cr_nxt = '0;
              cq_nxt = cq_r + 1'b1;
            end else begin
              cr_nxt = cr_r + 1'b1;
            end
          end
          lcol_nxt = col_inc;
          if (col_inc >= width_r) begin
            lcol_nxt = '0;
            cq_nxt   = '0;
            cr_nxt   = '0;
            lrow_nxt = lrow_r + 1'b1;
            if (({1'b0, rr_r} + 9'd1) == {1'b0, st}) begin
              rr_nxt = '0;
              rq_nxt = rq_r + 1'b1;
            end else begin
              rr_nxt = rr_r + 1'b1;
            end
          end
        end
      end

      // Fetch: resolve the grid position of the scan pointer
      ST_F_START: begin
        if (sp_r >= end_r) begin
          done_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          div_go     = 1'b1;
          div_num    = DIV_W'(sp_r);
          div_den_in = gw_r;
          div_ret    = ST_F_POS;
        end
      end

      ST_F_POS: begin
        gx_nxt    = div_rem_r[COORD_BITS-1:0];
        gy_nxt    = div_quo_r[COORD_BITS-1:0];
        p_nxt     = sp_r;
        state_nxt = ST_SCAN_RD;
      end

      ST_SCAN_RD: begin
        rd_addr   = p_r[ADDR_W-1:0];
        state_nxt = ST_SCAN_CHK;
      end

      ST_SCAN_CHK: begin
        if (!vis_rd_r && cell_rd_r[CELL_W-1]) begin
          base_nxt  = cell_rd_r[23:0];
          done_nxt  = 1'b0;
          spx_nxt   = SPAN_W'(1);
          spy_nxt   = SPAN_W'(1);
          dx_nxt    = '0;
          row_nxt   = NB_W'(p_r) + NB_W'(gw_r);
          mrow_nxt  = NB_W'(p_r);
          mdx_nxt   = '0;
          mdy_nxt   = '0;
          sp_nxt    = p_r + 1'b1;
          state_nxt = merge_r ? ST_RIGHT_RD : ST_MARK;
        end else if ((p_r + 1'b1) >= end_r) begin
          sp_nxt    = end_r;
          done_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          p_nxt = p_r + 1'b1;
          if ((gx_r + 1'b1) == gw_r) begin
            gx_nxt = '0;
            gy_nxt = gy_r + 1'b1;
          end else begin
            gx_nxt = gx_r + 1'b1;
          end
          state_nxt = ST_SCAN_RD;
        end
      end

      // Grow to the right
      ST_RIGHT_RD: begin
        rd_addr    = probe_idx[ADDR_W-1:0];
        idx_ok_nxt = probe_idx < NB_W'(GRID_CELLS);
        if (((COORD_BITS+1)'(gx_r) + (COORD_BITS+1)'(spx_r) <
             (COORD_BITS+1)'(gw_r)) && (spx_r < SPAN_W'(MAX_SPAN))) begin
          state_nxt = ST_RIGHT_CHK;
        end else begin
          state_nxt = ST_DOWN_RD;
        end
      end

      ST_RIGHT_CHK: begin
        if (join_ok) begin
          spx_nxt   = spx_r + 1'b1;
          state_nxt = ST_RIGHT_RD;
        end else begin
          state_nxt = ST_DOWN_RD;
        end
      end

      // Grow downwards, one whole row at a time
      ST_DOWN_RD: begin
        rd_addr    = probe_idx[ADDR_W-1:0];
        idx_ok_nxt = probe_idx < NB_W'(GRID_CELLS);
        if (((COORD_BITS+1)'(gy_r) + (COORD_BITS+1)'(spy_r) <
             (COORD_BITS+1)'(gh_r)) && (spy_r < SPAN_W'(MAX_SPAN))) begin
          state_nxt = ST_DOWN_CHK;
        end else begin
          state_nxt = ST_MARK;
        end
      end

      ST_DOWN_CHK: begin
        if (join_ok) begin
          if ((dx_r + 1'b1) == spx_r) begin
            dx_nxt  = '0;
            spy_nxt = spy_r + 1'b1;
            row_nxt = row_r + NB_W'(gw_r);
          end else begin
            dx_nxt = dx_r + 1'b1;
          end
          state_nxt = ST_DOWN_RD;
        end else begin
          state_nxt = ST_MARK;
        end
      end

      // Mark the rectangle visited, one cell a cycle
      ST_MARK: begin
        vis_wa = mark_idx[ADDR_W-1:0];
        vis_wd = 1'b1;
        vis_we = mark_idx < NB_W'(GRID_CELLS);
        if ((mdx_r + 1'b1) == spx_r) begin
          mdx_nxt = '0;
          if ((mdy_r + 1'b1) == spy_r) begin
            state_nxt = ST_HSV;
          end else begin
            mdy_nxt  = mdy_r + 1'b1;
            mrow_nxt = mrow_r + NB_W'(gw_r);
          end
        end else begin
          mdx_nxt = mdx_r + 1'b1;
        end
      end

      // Colour conversion through the shared divider
      ST_HSV: begin
        mx_nxt     = h_mx;
        d_nxt      = h_d;
        hnum_nxt   = h_num;
        div_go     = 1'b1;
        div_num    = DIV_W'(h_d) * DIV_W'(255);
        div_den_in = DEN_W'(h_mx);
        div_ret    = ST_SAT;
      end

      ST_SAT: begin
        sat_nxt    = (mx_r == 8'd0) ? 8'd0 : div_quo_r[7:0];
        div_go     = 1'b1;
        div_num    = DIV_W'(hnum_r) * DIV_W'(HUE_SEG);
        div_den_in = DEN_W'(d_r);
        div_ret    = ST_HUE;
      end

      ST_HUE: begin
        hue_nxt   = (d_r == 8'd0) ? 15'd0 : div_quo_r[14:0];
        state_nxt = ST_EMIT;
      end

      // Hand the result to the output register once it is free
      ST_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_done_nxt    = done_r;
          if (done_r) begin
            o_col_nxt = '0;
            o_row_nxt = '0;
            o_spx_nxt = '0;
            o_spy_nxt = '0;
            o_rgb_nxt = '0;
            o_hue_nxt = '0;
            o_sat_nxt = '0;
            o_val_nxt = '0;
          end else begin
            o_col_nxt = gx_r;
            o_row_nxt = gy_r;
            o_spx_nxt = 3'(spx_r);
            o_spy_nxt = 3'(spy_r);
            o_rgb_nxt = base_r;
            o_hue_nxt = hue_r;
            o_sat_nxt = sat_r;
            o_val_nxt = mx_r;
          end
          state_nxt = ST_IDLE;
        end
      end

      ST_DIV: begin
        div_rem_nxt = div_ge ? div_diff[DEN_W-1:0] : div_t[DEN_W-1:0];
        div_quo_nxt = {div_quo_r[DIV_W-2:0], div_ge};
        div_cnt_nxt = div_cnt_r - 1'b1;
        if (div_cnt_r == DCNT_W'(1)) begin
          state_nxt = ret_r;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Start of a division
    if (div_go) begin
      div_quo_nxt = div_num;
      div_rem_nxt = '0;
      div_den_nxt = div_den_in;
      div_cnt_nxt = DCNT_W'(DIV_W);
      ret_nxt     = div_ret;
      state_nxt   = ST_DIV;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      ret_r       <= ST_IDLE;
      step_r      <= 8'd1;
      tol_r       <= 8'd5;
      merge_r     <= 1'b1;
      width_r     <= COORD_BITS'(1);
      height_r    <= COORD_BITS'(1);
      gw_r        <= '0;
      gh_r        <= '0;
      end_r       <= '0;
      geo_r       <= '0;
      lcol_r      <= '0;
      lrow_r      <= '0;
      cq_r        <= '0;
      cr_r        <= '0;
      rq_r        <= '0;
      rr_r        <= '0;
      sp_r        <= '0;
      clr_r       <= '0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      step_r      <= step_nxt;
      tol_r       <= tol_nxt;
      merge_r     <= merge_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
      gw_r        <= gw_nxt;
      gh_r        <= gh_nxt;
      end_r       <= end_nxt;
      geo_r       <= geo_nxt;
      lcol_r      <= lcol_nxt;
      lrow_r      <= lrow_nxt;
      cq_r        <= cq_nxt;
      cr_r        <= cr_nxt;
      rq_r        <= rq_nxt;
      rr_r        <= rr_nxt;
      sp_r        <= sp_nxt;
      clr_r       <= clr_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pix_r     <= pix_nxt;
    prod_r    <= prod_nxt;
    p_r       <= p_nxt;
    gx_r      <= gx_nxt;
    gy_r      <= gy_nxt;
    base_r    <= base_nxt;
    spx_r     <= spx_nxt;
    spy_r     <= spy_nxt;
    dx_r      <= dx_nxt;
    row_r     <= row_nxt;
    idx_ok_r  <= idx_ok_nxt;
    mrow_r    <= mrow_nxt;
    mdx_r     <= mdx_nxt;
    mdy_r     <= mdy_nxt;
    mx_r      <= mx_nxt;
    d_r       <= d_nxt;
    hnum_r    <= hnum_nxt;
    sat_r     <= sat_nxt;
    hue_r     <= hue_nxt;
    done_r    <= done_nxt;
    div_quo_r <= div_quo_nxt;
    div_rem_r <= div_rem_nxt;
    div_den_r <= div_den_nxt;
    o_done_r  <= o_done_nxt;
    o_col_r   <= o_col_nxt;
    o_row_r   <= o_row_nxt;
    o_spx_r   <= o_spx_nxt;
    o_spy_r   <= o_spy_nxt;
    o_rgb_r   <= o_rgb_nxt;
    o_hue_r   <= o_hue_nxt;
    o_sat_r   <= o_sat_nxt;
    o_val_r   <= o_val_nxt;
  end

  // Cell memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cell_we) begin
      cell_mem[cell_wa] <= pix_r;
    end
    cell_rd_r <= cell_mem[rd_addr];
  end

  // Visited map: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (vis_we) begin
      vis_mem[vis_wa] <= vis_wd;
    end
    vis_rd_r <= vis_mem[rd_addr];
  end

  // Output ports
  assign out_valid            = out_valid_r;
  assign out_scan_done        = o_done_r;
  assign out_cell_column      = o_col_r;
  assign out_cell_row         = o_row_r;
  assign out_span_columns     = o_spx_r;
  assign out_span_rows        = o_spy_r;
  assign out_base_red         = o_rgb_r[23:16];
  assign out_base_green       = o_rgb_r[15:8];
  assign out_base_blue        = o_rgb_r[7:0];
  assign out_hue_value        = o_hue_r;
  assign out_saturation_value = o_sat_r;
  assign out_brightness_value = o_val_r;

  // A register write and an input item never complete together.
  a_cfg_excludes_item: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> in_stall)
    else $error("register write and input item accepted together");

  // Spans stay within limits while a rectangle is marked.
  a_span_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MARK) |-> (spx_r != '0) && (spy_r != '0) &&
    (spx_r <= SPAN_W'(MAX_SPAN)) && (spy_r <= SPAN_W'(MAX_SPAN)))
    else $error("span out of range while marking");

  // The scan pointer stays inside the grid while cells are read.
  a_scan_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_SCAN_RD) || (state_r == ST_SCAN_CHK)) |->
    (p_r < end_r) && (end_r <= SP_W'(GRID_CELLS)))
    else $error("scan pointer beyond grid end");

  // A result is never overwritten before it is taken.
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && (state_r == ST_EMIT)) |=> (state_r == ST_EMIT))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the pixel grid greedy block merger
// Drives images, fetches and stray items through the item channel, predicts
// every result with a behavioural model of the merger kept in this file, and
// compares each result item field by field under random idling and stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import pggbm_pkg::*;

  localparam logic [1:0] ACT_NONE = 2'd3;
  localparam int IDLE_LIMIT = 60000;
  localparam int CLEAR_WAIT = 17000;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_item_t;

  typedef struct packed {
    logic        done;
    logic [11:0] column;
    logic [11:0] row;
    logic [2:0]  span_x;
    logic [2:0]  span_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
  } block_t;

  logic clk;
  logic rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [1:0] in_action;
  logic [7:0] in_pixel_red, in_pixel_green, in_pixel_blue, in_pixel_alpha;
  logic out_valid, out_stall;
  logic out_scan_done;
  logic [11:0] out_cell_column, out_cell_row;
  logic [2:0] out_span_columns, out_span_rows;
  logic [7:0] out_base_red, out_base_green, out_base_blue;
  logic [14:0] out_hue_value;
  logic [7:0] out_saturation_value, out_brightness_value;

  pixel_grid_greedy_block_merger dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_pixel_red(in_pixel_red), .in_pixel_green(in_pixel_green),
    .in_pixel_blue(in_pixel_blue), .in_pixel_alpha(in_pixel_alpha),
    .out_valid(out_valid), .out_stall(out_stall), .out_scan_done(out_scan_done),
    .out_cell_column(out_cell_column), .out_cell_row(out_cell_row),
    .out_span_columns(out_span_columns), .out_span_rows(out_span_rows),
    .out_base_red(out_base_red), .out_base_green(out_base_green),
    .out_base_blue(out_base_blue), .out_hue_value(out_hue_value),
    .out_saturation_value(out_saturation_value),
    .out_brightness_value(out_brightness_value)
  );

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Shadow of the merger state
  int unsigned step_reg, tol_reg, merge_reg, width_reg, height_reg;
  logic [24:0] cell_mem [GRID_CELLS];
  bit          seen_map [GRID_CELLS];
  int unsigned load_x, load_y, scan_pos;

  pixel_item_t pending_items[$];
  block_t      expected_blocks[$];
  int          fail_count;
  int          idle_cycles;
  int          hold_requests, holds_served;
  logic [1:0]  last_action;

  function automatic int unsigned pitch();
    return (step_reg == 0) ? 1 : step_reg;
  endfunction

  function automatic int unsigned cols();
    return (width_reg + pitch() - 1) / pitch();
  endfunction

  function automatic int unsigned rows();
    return (height_reg + pitch() - 1) / pitch();
  endfunction

  function automatic bit close_to(int unsigned a, int unsigned b);
    return ((a > b) ? a - b : b - a) <= tol_reg;
  endfunction

  // A cell may join the block if it is stored, unvisited, opaque and close in colour
  function automatic bit joinable(int unsigned idx, logic [24:0] base);
    logic [24:0] c;
    if (idx >= GRID_CELLS || seen_map[idx]) return 1'b0;
    c = cell_mem[idx];
    if (!c[24]) return 1'b0;
    return close_to(c[23:16], base[23:16]) && close_to(c[15:8], base[15:8]) &&
           close_to(c[7:0], base[7:0]);
  endfunction

  // Store a sampled pixel and advance the raster position
  task automatic absorb_pixel(pixel_item_t it);
    int unsigned st, idx;
    st = pitch();
    if (load_y >= height_reg) return;
    if (load_x < width_reg) begin
      if (load_x % st == 0 && load_y % st == 0) begin
        idx = (load_y / st) * cols() + load_x / st;
        if (idx < GRID_CELLS)
          cell_mem[idx] = {it.alpha >= OPAQUE_MIN, it.red, it.green, it.blue};
      end
      load_x++;
    end
    if (load_x >= width_reg) begin
      load_x = 0;
      load_y = (load_y + 1) & 12'hFFF;
    end
  endtask

  // Find the next block, grow it, mark it and queue the expected result
  task automatic predict_block();
    int unsigned gw, gh, last, p, gx, gy, sx, sy, mx, mn, d, r, g, b, hue, sat;
    logic [24:0] base;
    bit ok;
    block_t res;
    gw = cols();
    gh = rows();
    last = gw * gh;
    if (last > GRID_CELLS) last = GRID_CELLS;
    res = '0;
    for (p = scan_pos; p < last; p++)
      if (!seen_map[p] && cell_mem[p][24]) break;
    if (p >= last) begin
      if (scan_pos < last) scan_pos = last;
      res.done = 1'b1;
      expected_blocks.push_back(res);
      return;
    end
    gx = p % gw;
    gy = p / gw;
    base = cell_mem[p];
    sx = 1;
    sy = 1;
    if (merge_reg[0]) begin
      while (gx + sx < gw && sx < MAX_SPAN && joinable(gy * gw + gx + sx, base)) sx++;
      while (gy + sy < gh && sy < MAX_SPAN) begin
        ok = 1'b1;
        for (int dx = 0; dx < sx && ok; dx++)
          ok = joinable((gy + sy) * gw + gx + dx, base);
        if (!ok) break;
        sy++;
      end
    end
    for (int dy = 0; dy < sy; dy++)
      for (int dx = 0; dx < sx; dx++)
        if ((gy + dy) * gw + gx + dx < GRID_CELLS) seen_map[(gy + dy) * gw + gx + dx] = 1'b1;
    scan_pos = p + 1;

    // Fixed-point HSV of the first cell
    r = base[23:16];
    g = base[15:8];
    b = base[7:0];
    mx = (r > g) ? r : g;
    if (b > mx) mx = b;
    mn = (r < g) ? r : g;
    if (b < mn) mn = b;
    d = mx - mn;
    sat = (mx > 0) ? (255 * d) / mx : 0;
    hue = 0;
    if (d != 0) begin
      if (mx == r)
        hue = (g >= b) ? (HUE_SEG * (g - b)) / d : (HUE_SEG * (6 * d - (b - g))) / d;
      else if (mx == g)
        hue = (HUE_SEG * (b + 2 * d - r)) / d;
      else
        hue = (HUE_SEG * (r + 4 * d - g)) / d;
    end
    res.column = gx[11:0];
    res.row = gy[11:0];
    res.span_x = sx[2:0];
    res.span_y = sy[2:0];
    res.red = r[7:0];
    res.green = g[7:0];
    res.blue = b[7:0];
    res.hue = hue[14:0];
    res.sat = sat[7:0];
    res.val = mx[7:0];
    expected_blocks.push_back(res);
  endtask

  task automatic apply_item(pixel_item_t it);
    case (it.action)
      ACT_BEGIN: begin
        for (int i = 0; i < GRID_CELLS; i++) seen_map[i] = 1'b0;
        load_x = 0;
        load_y = 0;
        scan_pos = 0;
      end
      ACT_LOAD:  absorb_pixel(it);
      ACT_FETCH: predict_block();
      default: ;
    endcase
  endtask

  // Driver: bursts of items separated by random gaps
  int burst_left, gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) begin
        apply_item({in_action, in_pixel_red, in_pixel_green, in_pixel_blue,
                    in_pixel_alpha});
        last_action = in_action;
      end
      if (pending_items.size() > 0 && gap_left == 0) begin
        pixel_item_t nxt;
        nxt = pending_items.pop_front();
        in_valid <= 1'b1;
        in_action <= nxt.action;
        in_pixel_red <= nxt.red;
        in_pixel_green <= nxt.green;
        in_pixel_blue <= nxt.blue;
        in_pixel_alpha <= nxt.alpha;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end
    end
  end

  // Receiver stall pattern, with an occasional long hold-off
  int stall_mode, mode_left, hold_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
      hold_left <= 0;
      holds_served <= 0;
    end else begin
      if (holds_served != hold_requests) begin
        holds_served <= hold_requests;
        hold_left <= 400;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= (hold_left > 1);
        1: out_stall <= (hold_left > 1) || ($urandom_range(0, 9) < 3);
        default: out_stall <= (hold_left > 1) || ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  // Result monitor and register shadow
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        block_t got, want;
        got = {out_scan_done, out_cell_column, out_cell_row, out_span_columns,
               out_span_rows, out_base_red, out_base_green, out_base_blue,
               out_hue_value, out_saturation_value, out_brightness_value};
        if (expected_blocks.size() == 0) begin
          $display("%0t: unexpected result item %h", $realtime, got);
          fail_count++;
        end else begin
          want = expected_blocks.pop_front();
          if (got.done != want.done)
            $display("%0t: scan_done exp %0d got %0d", $realtime, want.done, got.done);
          if (got.column != want.column)
            $display("%0t: cell_column exp %0d got %0d", $realtime, want.column, got.column);
          if (got.row != want.row)
            $display("%0t: cell_row exp %0d got %0d", $realtime, want.row, got.row);
          if (got.span_x != want.span_x)
            $display("%0t: span_columns exp %0d got %0d", $realtime, want.span_x, got.span_x);
          if (got.span_y != want.span_y)
            $display("%0t: span_rows exp %0d got %0d", $realtime, want.span_y, got.span_y);
          if (got.red != want.red)
            $display("%0t: base_red exp %0d got %0d", $realtime, want.red, got.red);
          if (got.green != want.green)
            $display("%0t: base_green exp %0d got %0d", $realtime, want.green, got.green);
          if (got.blue != want.blue)
            $display("%0t: base_blue exp %0d got %0d", $realtime, want.blue, got.blue);
          if (got.hue != want.hue)
            $display("%0t: hue_value exp %0d got %0d", $realtime, want.hue, got.hue);
          if (got.sat != want.sat)
            $display("%0t: saturation_value exp %0d got %0d", $realtime, want.sat, got.sat);
          if (got.val != want.val)
            $display("%0t: brightness_value exp %0d got %0d", $realtime, want.val, got.val);
          if (got != want) fail_count++;
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SAMPLE_STEP: step_reg = cfg_data[7:0];
          REG_COLOR_TOL:   tol_reg = cfg_data[7:0];
          REG_MERGE_EN:    merge_reg = cfg_data[0];
          REG_IMG_WIDTH:   width_reg = cfg_data;
          REG_IMG_HEIGHT:  height_reg = cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Watchdog on cycles without any accepted transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL pixel_grid_greedy_block_merger");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  int item_count;

  task automatic send(logic [1:0] act, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                      logic [7:0] a);
    pending_items.push_back({act, r, g, b, a});
    item_count++;
  endtask

  // Wait until every item is taken and every result has come, then let the
  // block settle for the given number of cycles
  task automatic drain(int settle);
    do @(posedge clk);
    while (pending_items.size() > 0 || expected_blocks.size() > 0 || in_valid);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Idle point before register writes: a begin or load may still be running
  task automatic quiesce();
    drain(0);
    repeat ((last_action == ACT_FETCH) ? 20 : CLEAR_WAIT) @(posedge clk);
  endtask

  task automatic setup(int unsigned st, int unsigned tol, int unsigned mrg,
                       int unsigned w, int unsigned h);
    quiesce();
    write_reg(REG_SAMPLE_STEP, st);
    write_reg(REG_COLOR_TOL, tol);
    write_reg(REG_MERGE_EN, mrg);
    write_reg(REG_IMG_WIDTH, w);
    write_reg(REG_IMG_HEIGHT, h);
  endtask

  // One full image in raster order, mostly near one colour so that blocks merge
  task automatic send_image(int unsigned w, int unsigned h);
    logic [7:0] br, bg, bb;
    br = $urandom;
    bg = $urandom;
    bb = $urandom;
    for (int i = 0; i < w * h; i++) begin
      if ($urandom_range(0, 9) < 7)
        send(ACT_LOAD, br ^ 8'($urandom_range(0, 3)), bg ^ 8'($urandom_range(0, 3)),
             bb ^ 8'($urandom_range(0, 3)),
             ($urandom_range(0, 4) != 0) ? 8'($urandom_range(200, 255))
                                         : 8'($urandom_range(0, 199)));
      else
        send(ACT_LOAD, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic send_fetches(int n);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 19))
        0: send(ACT_LOAD, $urandom, $urandom, $urandom, $urandom);
        1: send(ACT_NONE, $urandom, $urandom, $urandom, $urandom);
        default: ;
      endcase
      send(ACT_FETCH, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  initial begin
    int unsigned st, w, h, tol, phase;
    rst_n = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_action = ACT_BEGIN;
    in_pixel_red = '0;
    in_pixel_green = '0;
    in_pixel_blue = '0;
    in_pixel_alpha = '0;
    out_stall = 1'b0;
    fail_count = 0;
    item_count = 0;
    hold_requests = 0;
    last_action = ACT_BEGIN;
    step_reg = 1;
    tol_reg = 5;
    merge_reg = 1;
    width_reg = 1;
    height_reg = 1;
    for (int i = 0; i < GRID_CELLS; i++) begin
      cell_mem[i] = '0;
      seen_map[i] = 1'b0;
    end
    load_x = 0;
    load_y = 0;
    scan_pos = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Zero step acting as one, channel extremes, opacity threshold, stray items
    setup(0, 0, 1, 3, 2);
    send(ACT_BEGIN, 0, 0, 0, 0);
    send(ACT_LOAD, 255, 255, 255, 255);
    send(ACT_LOAD, 0, 0, 0, 200);
    send(ACT_LOAD, 0, 0, 0, 199);
    send(ACT_LOAD, 255, 0, 0, 255);
    send(ACT_LOAD, 0, 255, 0, 255);
    send(ACT_LOAD, 0, 0, 255, 255);
    send(ACT_LOAD, 9, 9, 9, 255);
    send(ACT_NONE, 255, 255, 255, 255);
    for (int i = 0; i < 6; i++) send(ACT_FETCH, 0, 0, 0, 0);

    // Width lowered part way through a row: the rest of the row is skipped
    setup(1, 255, 1, 4, 2);
    send(ACT_BEGIN, 0, 0, 0, 0);
    send(ACT_LOAD, 10, 20, 30, 255);
    send(ACT_LOAD, 11, 21, 31, 255);
    quiesce();
    write_reg(REG_IMG_WIDTH, 1);
    send(ACT_LOAD, 99, 99, 99, 255);
    send(ACT_LOAD, 12, 22, 32, 255);
    send(ACT_FETCH, 0, 0, 0, 0);
    send(ACT_FETCH, 0, 0, 0, 0);

    // Empty grid reports done at once
    quiesce();
    write_reg(REG_IMG_WIDTH, 0);
    send(ACT_FETCH, 0, 0, 0, 0);

    // 17 by 17 cells at pitch one, then the same cells read back at the widest
    // geometry: pitch 255 over a 4095 by 4095 image gives the same grid
    setup(1, 255, 1, 17, 17);
    send(ACT_BEGIN, 0, 0, 0, 0);
    send_image(17, 17);
    send_fetches(20);
    setup(255, 0, 0, 4095, 4095);
    send(ACT_BEGIN, 0, 0, 0, 0);
    send_fetches(60);

    // Random images with random geometry and settings
    phase = 0;
    while (item_count < 1100) begin
      st = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(2, 4);
      w = $urandom_range(1, 14);
      h = $urandom_range(1, 10);
      case ($urandom_range(0, 3))
        0: tol = 0;
        1: tol = 255;
        default: tol = $urandom_range(0, 24);
      endcase
      setup(st, tol, ($urandom_range(0, 3) != 0), w, h);
      send(ACT_BEGIN, $urandom, $urandom, $urandom, $urandom);
      send_image(w, h);
      if (phase == 1) begin
        drain(0);
        hold_requests++;
      end
      send_fetches((((w + st - 1) / st) * ((h + st - 1) / st)) / 2 + 1);
      if (phase == 2) drain(0);
      send_fetches((((w + st - 1) / st) * ((h + st - 1) / st)) / 2 + 2);
      phase++;
    end

    drain(200);
    if (fail_count == 0) begin
      $display("PASS pixel_grid_greedy_block_merger");
    end else begin
      $display("FAIL pixel_grid_greedy_block_merger");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
design/pggbm_pkg.sv
design/pixel_grid_greedy_block_merger.sv
tb/tb_top.sv
